/* rtl/pwmt_pkg.sv */
// Shared types, codes and constants of the four-channel PWM timer.
// Depends on nothing; every other file of the block but pwmt_fifo imports it.
package pwmt_pkg;

    localparam int TICK_CLOCK_HZ_DEF = 21000000;
    localparam int NUM_CHANNELS_DEF  = 4;
    localparam int COUNTER_BITS_DEF  = 16;

    localparam int FREQ_W       = 20;
    localparam int DUTY_W       = 15;
    localparam int FULL_DUTY    = 25600;
    localparam int RESET_PERIOD = 1050 - 1;
    localparam int PIN_W        = 4;

    // Full duty is 100 percent in Q8.8, so the scale splits into a shift and a divide by 100.
    localparam int DUTY_FRAC_BITS = 8;
    localparam int FULL_PERCENT   = 100;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_SET_DUTY = 2'd1;
    localparam logic [1:0] CMD_SET_ALL  = 2'd2;
    localparam logic [1:0] CMD_SET_FREQ = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [1:0]        channel;
        logic [19:0]       freq_hz;
        logic signed [15:0] duty_q8;
    } item_t;

    typedef struct packed {
        logic [3:0]  pin_levels;
        logic [15:0] counter_now;
        logic [15:0] period_now;
        logic        stopped;
    } result_t;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_NOP      = 3'd1,
        OP_STOP     = 3'd2,
        OP_SET_CH   = 3'd3,
        OP_SET_ALL  = 3'd4,
        OP_SET_FREQ = 3'd5
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [1:0]        channel;
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
    } entry_t;

endpackage

/* rtl/four_channel_pwm_duty_timer.sv */
// Top level of the four-channel edge-aligned PWM timer.
// Depends on pwmt_pkg, pwmt_front and pwmt_back.
//
// Usage: command words enter through a queue-like port (push, full, item).
// A word is taken at a clock edge with push high and full low. Every word
// yields exactly one result word, presented on result while empty is low
// and taken at an edge with pop high. Results come out in command order.
// A tick word advances the counter; the other words write the shadow period
// and compare registers, which load into the active ones at each wrap.
// Ticks, stops and ignored channel writes are committed straight from the
// head of the input queue into the result queue, and a stream of them runs
// at one word per cycle while the result queue has room. A duty write steps
// through period multiply, reciprocal scale and commit. A frequency write
// runs a serial division of width DVD_W, DVD_W = max(bits of TICK_CLOCK_HZ,
// COUNTER_BITS + 1), 25 at the default settings, then commits; a combined write
// runs the division, then the multiply, scale and commit. Words behind a slow
// one wait in a two-word queue. Reset clears the counter and compares and
// sets the period to 1049. A stalled receiver fills the two-word result
// queue and then the input queue, after which full rises; nothing is lost.
module four_channel_pwm_duty_timer import pwmt_pkg::*; #(
    parameter int TICK_CLOCK_HZ = TICK_CLOCK_HZ_DEF,
    parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF,
    parameter int COUNTER_BITS  = COUNTER_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    entry_t head;
    logic   head_empty;
    logic   head_pop;

    pwmt_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .head       (head),
        .head_empty (head_empty),
        .head_pop   (head_pop)
    );

    pwmt_back #(
        .TICK_CLOCK_HZ (TICK_CLOCK_HZ),
        .NUM_CHANNELS  (NUM_CHANNELS),
        .COUNTER_BITS  (COUNTER_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    // The back end only retires a word that the front queue actually holds.
    assert property (@(posedge clk) disable iff (!rst_n) head_pop |-> !head_empty)
        else $error("back end retired a word from an empty queue");

    // Every retired word leaves a result waiting in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) head_pop |=> !empty)
        else $error("retired word produced no result");

    // A full input queue means the back end has a word to work on.
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !head_empty)
        else $error("input queue full while back end sees nothing");

endmodule

/* rtl/pwmt_fifo.sv */
// Two-word queue built from two register slots; the head slot drives the output.
// Depends on nothing but its width parameter.
module pwmt_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    logic             v0_reg, v1_reg;
    logic [WIDTH-1:0] s0_reg, s1_reg;
    logic             do_push, do_pop;

    assign full    = v1_reg;
    assign empty   = !v0_reg;
    assign dout    = s0_reg;
    assign do_push = push && !v1_reg;
    assign do_pop  = pop && v0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (do_pop && !do_push)
        begin
            v0_reg <= v1_reg;
            v1_reg <= 1'b0;
        end
        else if (do_push && !do_pop)
        begin
            if (v0_reg)
                v1_reg <= 1'b1;
            else
                v0_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop && do_push)
            s0_reg <= din;
        else if (do_pop)
            s0_reg <= s1_reg;
        else if (do_push)
        begin
            if (v0_reg)
                s1_reg <= din;
            else
                s0_reg <= din;
        end
    end

endmodule

/* rtl/pwmt_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Depends on pwmt_pkg for the divisor width.
module pwmt_div import pwmt_pkg::*; #(
    parameter int DVD_W = 31
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [FREQ_W-1:0] divisor,
    output logic              done,
    output logic [DVD_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [FREQ_W-1:0] rem_reg;
    logic [FREQ_W-1:0] dvs_reg;
    logic [FREQ_W:0]   trial;
    logic              fits;

    assign trial    = {rem_reg, quo_reg[DVD_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(DVD_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
            done_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            if (fits)
                rem_reg <= FREQ_W'(trial - {1'b0, dvs_reg});
            else
                rem_reg <= trial[FREQ_W-1:0];
        end
    end

endmodule

/* rtl/pwmt_front.sv */
// Input side: takes command words, decodes them into operations and queues them.
// Depends on pwmt_pkg and pwmt_fifo.
module pwmt_front import pwmt_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    output logic   full,
    input  item_t  item,
    output entry_t head,
    output logic   head_empty,
    input  logic   head_pop
);

    entry_t            entry;
    logic [DUTY_W-1:0] duty_clamped;
    logic [$bits(entry_t)-1:0] head_bits;

    always_comb
    begin
        if (item.duty_q8 < 16'sd0)
            duty_clamped = '0;
        else if (item.duty_q8 > $signed(16'(FULL_DUTY)))
            duty_clamped = DUTY_W'(FULL_DUTY);
        else
            duty_clamped = item.duty_q8[DUTY_W-1:0];

        entry.channel = item.channel;
        entry.freq    = item.freq_hz;
        entry.duty    = duty_clamped;
        case (item.cmd)
            CMD_TICK:
                entry.op = OP_TICK;
            CMD_SET_DUTY:
                entry.op = (int'(item.channel) >= NUM_CHANNELS) ? OP_NOP : OP_SET_CH;
            CMD_SET_ALL:
                entry.op = (item.freq_hz == '0 || item.duty_q8 <= 16'sd0) ? OP_STOP
                                                                           : OP_SET_ALL;
            CMD_SET_FREQ:
                entry.op = (item.freq_hz == '0) ? OP_STOP : OP_SET_FREQ;
            default:
                entry.op = OP_NOP;
        endcase
    end

    pwmt_fifo #(
        .WIDTH ($bits(entry_t))
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (entry),
        .full  (full),
        .pop   (head_pop),
        .dout  (head_bits),
        .empty (head_empty)
    );

    assign head = entry_t'(head_bits);

endmodule

/* rtl/pwmt_back.sv */
// Execution side: timer state, period and compare arithmetic, result queue.
// Depends on pwmt_pkg, pwmt_div and pwmt_fifo.
module pwmt_back import pwmt_pkg::*; #(
    parameter int TICK_CLOCK_HZ = TICK_CLOCK_HZ_DEF,
    parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF,
    parameter int COUNTER_BITS  = COUNTER_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  entry_t  head,
    input  logic    head_empty,
    output logic    head_pop,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    localparam int CB      = COUNTER_BITS;
    localparam int PROD_W  = CB + DUTY_W;
    localparam int TICK_W  = $clog2(TICK_CLOCK_HZ + 1);
    localparam int DVD_W   = (TICK_W > CB) ? TICK_W : CB + 1;
    localparam int PIN_N   = (NUM_CHANNELS < PIN_W) ? NUM_CHANNELS : PIN_W;

    // Divide by 100 through a rounded-up reciprocal; the extra bits keep the
    // reciprocal error below one part in 2^7, which makes the floor exact.
    localparam int SCL_W     = PROD_W - DUTY_FRAC_BITS;
    localparam int RCP_GUARD = 7;
    localparam int RCP_K     = SCL_W + RCP_GUARD;
    localparam int RCP_W     = SCL_W + 1;
    localparam int SPROD_W   = SCL_W + RCP_W;
    localparam logic [63:0] RCP_FULL = ((64'd1 << RCP_K) + 64'(FULL_PERCENT - 1))
                                       / 64'(FULL_PERCENT);
    localparam logic [RCP_W-1:0] RCP = RCP_FULL[RCP_W-1:0];

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL    = 5'b00010,
        ST_SCALE  = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_COMMIT = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic            start_reg, start_next;
    logic [CB-1:0]   count_reg, count_next;
    logic [CB-1:0]   per_act_reg, per_act_next;
    logic [CB-1:0]   per_shd_reg, per_shd_next;
    logic [CB-1:0]   cmp_act_reg [NUM_CHANNELS];
    logic [CB-1:0]   cmp_act_next [NUM_CHANNELS];
    logic [CB-1:0]   cmp_shd_reg [NUM_CHANNELS];
    logic [CB-1:0]   cmp_shd_next [NUM_CHANNELS];

    logic [CB-1:0]     mul_a_reg, mul_a_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [CB-1:0]     per_val_reg, per_val_next;
    logic [CB-1:0]     cmp_val_reg, cmp_val_next;

    logic [SCL_W-1:0]   scl_in;
    logic [SPROD_W-1:0] scl_prod;

    logic              div_done;
    logic [DVD_W-1:0]  div_quo;
    logic [DVD_W-1:0]  quo_less;
    logic [CB-1:0]     per_sat;
    logic [DVD_W-1:0]  div_dividend;
    logic [FREQ_W-1:0] div_divisor;

    logic              room;
    logic              out_full;
    logic              immediate;
    logic              commit;
    result_t           res;
    logic [31:0]       count_wide, period_wide;

    assign div_dividend = DVD_W'(TICK_CLOCK_HZ);
    assign div_divisor  = head.freq;

    pwmt_div #(
        .DVD_W (DVD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Period is quotient minus one, floored at zero and saturated to the counter width.
    assign quo_less = div_quo - 1'b1;
    always_comb
    begin
        if (div_quo == '0)
            per_sat = '0;
        else if (quo_less[DVD_W-1:CB] != '0)
            per_sat = '1;
        else
            per_sat = quo_less[CB-1:0];
    end

    // Compare value is floor(period * duty / 25600): drop the fraction bits, then divide by 100.
    assign scl_in   = prod_reg[PROD_W-1:DUTY_FRAC_BITS];
    assign scl_prod = SPROD_W'(scl_in) * SPROD_W'(RCP);

    assign room      = !out_full;
    assign immediate = (head.op == OP_TICK) || (head.op == OP_NOP) || (head.op == OP_STOP);
    assign commit    = !head_empty && room &&
                       (((state_reg == ST_IDLE) && immediate) || (state_reg == ST_COMMIT));
    assign head_pop  = commit;

    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        mul_a_next     = mul_a_reg;
        prod_next      = prod_reg;
        per_val_next   = per_val_reg;
        cmp_val_next   = cmp_val_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!head_empty)
                begin
                    case (head.op)
                        OP_SET_CH:
                        begin
                            mul_a_next = per_shd_reg;
                            state_next = ST_MUL;
                        end
                        OP_SET_ALL, OP_SET_FREQ:
                        begin
                            start_next = 1'b1;
                            state_next = ST_DIV;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(mul_a_reg) * PROD_W'(head.duty);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmp_val_next = scl_prod[RCP_K +: CB];
                state_next   = ST_COMMIT;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    per_val_next = per_sat;
                    if (head.op == OP_SET_ALL)
                    begin
                        // The new period feeds the duty product before anything commits.
                        mul_a_next = per_sat;
                        state_next = ST_MUL;
                    end
                    else
                        state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (commit)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        per_act_next = per_act_reg;
        per_shd_next = per_shd_reg;
        cmp_act_next = cmp_act_reg;
        cmp_shd_next = cmp_shd_reg;
        if (commit)
        begin
            case (head.op)
                OP_TICK:
                begin
                    if (count_reg >= per_act_reg)
                    begin
                        count_next   = '0;
                        per_act_next = per_shd_reg;
                        cmp_act_next = cmp_shd_reg;
                    end
                    else
                        count_next = count_reg + 1'b1;
                end
                OP_SET_CH:
                begin
                    for (int n = 0; n < NUM_CHANNELS; n++)
                    begin
                        if (int'(head.channel) == n)
                            cmp_shd_next[n] = cmp_val_reg;
                    end
                end
                OP_SET_ALL:
                begin
                    per_shd_next = per_val_reg;
                    for (int n = 0; n < NUM_CHANNELS; n++)
                        cmp_shd_next[n] = cmp_val_reg;
                end
                OP_SET_FREQ:
                    per_shd_next = per_val_reg;
                OP_STOP:
                begin
                    for (int n = 0; n < NUM_CHANNELS; n++)
                        cmp_shd_next[n] = '0;
                end
                default:
                    count_next = count_reg;
            endcase
        end
    end

    // The result word reports the state as it stands after this word is carried out.
    always_comb
    begin
        count_wide  = 32'(count_next);
        period_wide = 32'(per_shd_next);
        res.pin_levels = '0;
        for (int n = 0; n < PIN_N; n++)
            res.pin_levels[n] = count_next < cmp_act_next[n];
        res.counter_now = count_wide[15:0];
        res.period_now  = period_wide[15:0];
        res.stopped     = (head.op == OP_STOP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            count_reg     <= '0;
            per_act_reg   <= CB'(RESET_PERIOD);
            per_shd_reg   <= CB'(RESET_PERIOD);
            for (int n = 0; n < NUM_CHANNELS; n++)
            begin
                cmp_act_reg[n] <= '0;
                cmp_shd_reg[n] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            count_reg     <= count_next;
            per_act_reg   <= per_act_next;
            per_shd_reg   <= per_shd_next;
            cmp_act_reg   <= cmp_act_next;
            cmp_shd_reg   <= cmp_shd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg   <= mul_a_next;
        prod_reg    <= prod_next;
        per_val_reg <= per_val_next;
        cmp_val_reg <= cmp_val_next;
    end

    pwmt_fifo #(
        .WIDTH ($bits(result_t))
    ) u_results (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (commit),
        .din   (res),
        .full  (out_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

endmodule
